// ===== sv/assert_macros.svh =====
// Assertion macros shared by the sprite row decoder RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPRD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sprd_pkg.sv =====
// Shared types and constants for the sprite run-length row decoder.
// No dependencies; imported by sprd_step and the top level.
package sprd_pkg;

  typedef enum logic [2:0] {
    REG_CODING_MODE = 3'd0,
    REG_ROW_WIDTH   = 3'd1,
    REG_ROW_COUNT   = 3'd2,
    REG_LEFT_MARGIN = 3'd3,
    REG_TOP_MARGIN  = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] MODE_RAW        = 2'd0;
  localparam logic [1:0] MODE_PAIR       = 2'd1;
  localparam logic [1:0] MODE_PACKED     = 2'd2;
  localparam logic [1:0] MODE_PACKED_ALT = 2'd3;

  localparam logic [7:0] PAIR_LITERAL_TYPE   = 8'hFF;
  localparam logic [2:0] PACKED_LITERAL_KIND = 3'd7;

  // Segment header state carried from byte to byte.
  typedef struct packed {
    logic [7:0] held_type;
    logic [8:0] literals_left;
    logic       type_pending;
    logic       finished;
  } hdr_state_t;

  // Result flags of one decode step.
  typedef struct packed {
    logic produce;
    logic done;
  } step_flags_t;

endpackage

// ===== sv/sprd_step.sv =====
// One decode step: header decode, run clipping and row/image end handling.
// Pure combinational; uses sprd_pkg for header state and flag structs.
module sprd_step
  import sprd_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic [1:0]            coding_mode,
  input  logic [COORD_BITS-1:0] row_width,
  input  logic [COORD_BITS-1:0] row_count,
  input  logic [COORD_BITS-1:0] left_margin,
  input  logic [COORD_BITS-1:0] top_margin,
  input  logic [7:0]            data_byte,
  input  logic [COORD_BITS:0]   col_pos,
  input  logic [COORD_BITS-1:0] row_pos,
  input  hdr_state_t            hdr,
  output logic [COORD_BITS:0]   col_pos_next,
  output logic [COORD_BITS-1:0] row_pos_next,
  output hdr_state_t            hdr_next,
  output step_flags_t           flags,
  output logic [COORD_BITS:0]   pos_x,
  output logic [COORD_BITS:0]   pos_y,
  output logic [8:0]            run_count,
  output logic [7:0]            pixel_value
);

  localparam int PW = COORD_BITS + 1;

  logic          place;
  logic [8:0]    run_len;
  hdr_state_t    hdr_dec;
  logic          in_row;
  logic [PW-1:0] width_ext;
  logic [PW-1:0] room;
  logic [PW-1:0] len_ext;
  logic [PW-1:0] cnt_wide;
  logic [PW-1:0] col_after;
  logic          last_row;

  always_comb begin
    hdr_dec     = hdr;
    place       = 1'b0;
    run_len     = 9'd1;
    pixel_value = data_byte;
    if (hdr.finished) begin
      place = 1'b0;
    end else if (hdr.literals_left != 9'd0) begin
      hdr_dec.literals_left = hdr.literals_left - 9'd1;
      place = 1'b1;
    end else begin
      unique case (coding_mode)
        MODE_RAW: begin
          place = 1'b1;
        end
        MODE_PAIR: begin
          if (!hdr.type_pending) begin
            hdr_dec.held_type    = data_byte;
            hdr_dec.type_pending = 1'b1;
          end else begin
            hdr_dec.type_pending = 1'b0;
            if (hdr.held_type == PAIR_LITERAL_TYPE) begin
              hdr_dec.literals_left = {1'b0, data_byte} + 9'd1;
            end else begin
              place       = 1'b1;
              run_len     = {1'b0, data_byte} + 9'd1;
              pixel_value = hdr.held_type;
            end
          end
        end
        MODE_PACKED, MODE_PACKED_ALT: begin
          if (data_byte[7:5] == PACKED_LITERAL_KIND) begin
            hdr_dec.literals_left = {4'd0, data_byte[4:0]} + 9'd1;
          end else begin
            place       = 1'b1;
            run_len     = {4'd0, data_byte[4:0]} + 9'd1;
            pixel_value = {5'd0, data_byte[7:5]};
          end
        end
        default: begin
          place = 1'b0;
        end
      endcase
    end
  end

  assign width_ext = PW'(row_width);
  assign in_row    = col_pos < width_ext;
  assign room      = width_ext - col_pos;
  assign len_ext   = PW'(run_len);
  assign cnt_wide  = (len_ext < room) ? len_ext : room;
  assign col_after = (place && in_row) ? (col_pos + cnt_wide) : col_pos;
  assign last_row  = (PW'(row_pos) + PW'(1)) >= PW'(row_count);

  always_comb begin
    hdr_next      = hdr_dec;
    col_pos_next  = col_after;
    row_pos_next  = row_pos;
    flags.produce = place && in_row;
    flags.done    = 1'b0;
    if (place && (col_after >= width_ext)) begin
      if (last_row) begin
        hdr_next.finished      = 1'b1;
        hdr_next.literals_left = 9'd0;
        hdr_next.type_pending  = 1'b0;
        flags.done             = in_row;
      end else if (hdr_dec.literals_left == 9'd0) begin
        col_pos_next = '0;
        row_pos_next = row_pos + COORD_BITS'(1);
      end
    end
  end

  assign run_count     = cnt_wide[8:0];
  assign pos_x         = PW'(left_margin) + col_pos;
  assign pos_y         = PW'(top_margin) + PW'(row_pos);

endmodule

// ===== sv/sprite_rle_row_decoder.sv =====
// Top level of the sprite run-length row decoder.
// Depends on sprd_pkg, sprd_step and assert_macros.svh.
//
// Usage: compressed row bytes enter on the in_valid/in_ready channel, one
// byte per transfer, and pixel runs leave on the out_valid/out_ready channel.
// Each run gives a margin-adjusted start position, a length of 1 to 256 and
// a palette index; image_done marks the run that completes the last row.
// Header bytes, clipped literals and bytes after the image end give no run.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// A transferred byte is held in the input register and decoded from there; its
// run is captured in the result register when the byte leaves the input register.
// Throughput is one byte per cycle unless a run waits on a stalled receiver.
// The decode between the input and result registers is combinational; the
// column, row and header state registers are updated once per byte.
// When the receiver stalls, the result register holds its run and the input
// register still takes one more byte; a byte that would produce a run waits
// there until the result register frees, while bytes giving no run pass on.
// Reset (rst, synchronous) clears the valid flags and decode state and sets
// the registers to raw mode, one pixel by one row, zero margins.
module sprite_rle_row_decoder
  import sprd_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS:0]   pos_x,
  output logic [COORD_BITS:0]   pos_y,
  output logic [8:0]            run_count,
  output logic [7:0]            pixel_value,
  output logic                  image_done
);

  `include "assert_macros.svh"

  logic [1:0]            coding_mode;
  logic [COORD_BITS-1:0] row_width;
  logic [COORD_BITS-1:0] row_count;
  logic [COORD_BITS-1:0] left_margin;
  logic [COORD_BITS-1:0] top_margin;

  logic [COORD_BITS:0]   col_pos;
  logic [COORD_BITS-1:0] row_pos;
  hdr_state_t            hdr;

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  s1_fire;

  logic [COORD_BITS:0]   col_pos_next;
  logic [COORD_BITS-1:0] row_pos_next;
  hdr_state_t            hdr_next;
  step_flags_t           flags;
  logic [COORD_BITS:0]   res_x;
  logic [COORD_BITS:0]   res_y;
  logic [8:0]            res_count;
  logic [7:0]            res_value;

  sprd_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .coding_mode (coding_mode),
    .row_width   (row_width),
    .row_count   (row_count),
    .left_margin (left_margin),
    .top_margin  (top_margin),
    .data_byte   (s1_byte),
    .col_pos     (col_pos),
    .row_pos     (row_pos),
    .hdr         (hdr),
    .col_pos_next(col_pos_next),
    .row_pos_next(row_pos_next),
    .hdr_next    (hdr_next),
    .flags       (flags),
    .pos_x       (res_x),
    .pos_y       (res_y),
    .run_count   (res_count),
    .pixel_value (res_value)
  );

  assign s1_fire  = s1_valid && (!flags.produce || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      coding_mode <= MODE_RAW;
      row_width   <= COORD_BITS'(1);
      row_count   <= COORD_BITS'(1);
      left_margin <= '0;
      top_margin  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CODING_MODE: coding_mode <= cfg_data[1:0];
        REG_ROW_WIDTH:   row_width   <= cfg_data;
        REG_ROW_COUNT:   row_count   <= cfg_data;
        REG_LEFT_MARGIN: left_margin <= cfg_data;
        REG_TOP_MARGIN:  top_margin  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      hdr     <= '0;
    end else if (s1_fire) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
      hdr     <= hdr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && flags.produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && flags.produce) begin
      pos_x       <= res_x;
      pos_y       <= res_y;
      run_count   <= res_count;
      pixel_value <= res_value;
      image_done  <= flags.done;
    end
  end

  `SPRD_ASSERT_NEXT(a_finished_sticky, hdr.finished, hdr.finished,
                    "finished flag cleared without reset")
  `SPRD_ASSERT_SAME(a_done_implies_finished, out_valid && image_done, hdr.finished,
                    "image_done shown while the image is not finished")
  `SPRD_ASSERT_SAME(a_stall_from_output, s1_valid && !in_ready,
                    out_valid && !out_ready && flags.produce,
                    "input stalled without a blocked result")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sprite_rle_row_decoder: directed table, then random byte streams.
// Depends on sprd_pkg and the decoder RTL. Expected runs: local decode model or the table.
module tb_top;
  import sprd_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [COORD_BITS:0] pos_x;
    logic [COORD_BITS:0] pos_y;
    logic [8:0]          count;
    logic [7:0]          value;
    logic                done;
  } run_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_BYTE,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cfg_reg_t  reg_idx;
    logic [11:0] value;
    run_t      exp_run;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  cfg_reg_t cfg_index = REG_CODING_MODE;
  logic [COORD_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COORD_BITS:0] pos_x;
  logic [COORD_BITS:0] pos_y;
  logic [8:0] run_count;
  logic [7:0] pixel_value;
  logic image_done;

  // Decoder state and register copies, mirroring the block after reset.
  logic [1:0] cfg_mode = MODE_RAW;
  int cfg_width = 1;
  int cfg_rows = 1;
  int cfg_left = 0;
  int cfg_top = 0;
  int col_pos = 0;
  int row_pos = 0;
  logic [7:0] held_type = 8'h00;
  bit hdr_pending = 1'b0;
  int lits_left = 0;
  bit img_finished = 1'b0;

  run_t runs_due[$];
  int failures = 0;
  int items_sent = 0;
  int send_idle = 15;
  int recv_idle = 82;
  bit cur_typed = 1'b0;
  run_t cur_exp = '0;
  plan_row_t plan [40];

  sprite_rle_row_decoder #(.COORD_BITS(COORD_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .run_count(run_count),
    .pixel_value(pixel_value),
    .image_done(image_done)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit decode_run(input logic [7:0] b, output run_t r);
    int y_start;
    int x_start;
    int len;
    int room;
    int cnt;
    logic [7:0] val;
    bit placed;
    bit done;
    r = '0;
    if (img_finished) return 1'b0;
    y_start = row_pos;
    len = 1;
    val = b;
    if (lits_left != 0) begin
      lits_left = lits_left - 1;
    end else if (cfg_mode == MODE_PAIR) begin
      if (!hdr_pending) begin
        held_type = b;
        hdr_pending = 1'b1;
        return 1'b0;
      end
      hdr_pending = 1'b0;
      if (held_type == PAIR_LITERAL_TYPE) begin
        lits_left = b + 1;
        return 1'b0;
      end
      len = b + 1;
      val = held_type;
    end else if (cfg_mode != MODE_RAW) begin
      len = b[4:0] + 1;
      if (b[7:5] == PACKED_LITERAL_KIND) begin
        lits_left = len;
        return 1'b0;
      end
      val = {5'd0, b[7:5]};
    end
    x_start = col_pos;
    placed = 1'b0;
    cnt = 0;
    if (col_pos < cfg_width) begin
      room = cfg_width - col_pos;
      cnt = (len < room) ? len : room;
      col_pos = col_pos + cnt;
      placed = 1'b1;
    end
    done = 1'b0;
    if (col_pos >= cfg_width) begin
      if (row_pos + 1 >= cfg_rows) begin
        img_finished = 1'b1;
        lits_left = 0;
        hdr_pending = 1'b0;
        done = 1'b1;
      end else if (lits_left == 0) begin
        col_pos = 0;
        row_pos = (row_pos + 1) % (1 << COORD_BITS);
      end
    end
    r.pos_x = (COORD_BITS+1)'(cfg_left + x_start);
    r.pos_y = (COORD_BITS+1)'(cfg_top + y_start);
    r.count = 9'(cnt);
    r.value = val;
    r.done = done;
    return placed;
  endfunction

  // Every call starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input run_t exp_run = '0);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cur_typed = typed;
    cur_exp = exp_run;
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (runs_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [11:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CODING_MODE: cfg_mode = val[1:0];
      REG_ROW_WIDTH:   cfg_width = int'(val);
      REG_ROW_COUNT:   cfg_rows = int'(val);
      REG_LEFT_MARGIN: cfg_left = int'(val);
      REG_TOP_MARGIN:  cfg_top = int'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // One header with its literal bytes, one fill header, or a stray byte.
  task automatic send_segment();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if (cfg_mode == MODE_RAW || pick == 9) begin
      send_byte(8'($urandom));
    end else if (pick < 3) begin
      n = $urandom_range(0, 7);
      if ($urandom_range(0, 15) == 0) begin
        n = (cfg_mode == MODE_PAIR) ? $urandom_range(0, 255) : $urandom_range(0, 31);
      end
      if (cfg_mode == MODE_PAIR) begin
        send_byte(PAIR_LITERAL_TYPE);
        send_byte(8'(n));
      end else begin
        send_byte({PACKED_LITERAL_KIND, 5'(n)});
      end
      repeat (n + 1) send_byte(8'($urandom));
    end else if (cfg_mode == MODE_PAIR) begin
      send_byte(8'($urandom_range(0, 254)));
      send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)));
    end else begin
      send_byte({3'($urandom_range(0, 6)), 5'($urandom)});
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin : monitor
    run_t got;
    run_t exp;
    bit has_run;
    if (!rst) begin
      if (in_valid && in_ready) begin
        has_run = decode_run(data_byte, got);
        if (cur_typed) runs_due.push_back(cur_exp);
        else if (has_run) runs_due.push_back(got);
      end
      if (out_valid && out_ready) begin
        if (runs_due.size() == 0) begin
          $error("unexpected run at x %0d y %0d", pos_x, pos_y);
          failures++;
        end else begin
          exp = runs_due.pop_front();
          if (pos_x !== exp.pos_x) begin
            $error("pos_x: expected %0d, got %0d", exp.pos_x, pos_x);
            failures++;
          end
          if (pos_y !== exp.pos_y) begin
            $error("pos_y: expected %0d, got %0d", exp.pos_y, pos_y);
            failures++;
          end
          if (run_count !== exp.count) begin
            $error("run_count: expected %0d, got %0d", exp.count, run_count);
            failures++;
          end
          if (pixel_value !== exp.value) begin
            $error("pixel_value: expected %0d, got %0d", exp.value, pixel_value);
            failures++;
          end
          if (image_done !== exp.done) begin
            $error("image_done: expected %0d, got %0d", exp.done, image_done);
            failures++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int pass_no;
    int pass_end;
    int sub_end;
    int pick;
    logic [11:0] width;
    logic [11:0] rows;
    logic [11:0] left;
    logic [11:0] top;

    plan = '{
      '{ROW_CFG, REG_CODING_MODE, 12'(MODE_RAW), '0},
      '{ROW_CFG, REG_ROW_WIDTH, 12'd4, '0},
      '{ROW_CFG, REG_ROW_COUNT, 12'd4095, '0},
      '{ROW_CFG, REG_LEFT_MARGIN, 12'd0, '0},
      '{ROW_CFG, REG_TOP_MARGIN, 12'd0, '0},
      '{ROW_TYPED, REG_CODING_MODE, 12'h000, '{13'd0, 13'd0, 9'd1, 8'h00, 1'b0}},
      '{ROW_TYPED, REG_CODING_MODE, 12'h0FF, '{13'd1, 13'd0, 9'd1, 8'hFF, 1'b0}},
      '{ROW_TYPED, REG_CODING_MODE, 12'h05A, '{13'd2, 13'd0, 9'd1, 8'h5A, 1'b0}},
      '{ROW_TYPED, REG_CODING_MODE, 12'h0A5, '{13'd3, 13'd0, 9'd1, 8'hA5, 1'b0}},
      '{ROW_CFG, REG_LEFT_MARGIN, 12'd4095, '0},
      '{ROW_CFG, REG_TOP_MARGIN, 12'd4095, '0},
      '{ROW_CFG, REG_CODING_MODE, 12'(MODE_PAIR), '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h007, '0},
      '{ROW_TYPED, REG_CODING_MODE, 12'h0FF, '{13'd4095, 13'd4096, 9'd4, 8'h07, 1'b0}},
      '{ROW_BYTE, REG_CODING_MODE, 12'(PAIR_LITERAL_TYPE), '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h005, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h000, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h0FF, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h001, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h080, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h07F, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h0FE, '0},
      '{ROW_CFG, REG_CODING_MODE, 12'(MODE_PACKED), '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'({PACKED_LITERAL_KIND, 5'd1}), '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h012, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h034, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h01F, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h0DF, '0},
      '{ROW_CFG, REG_CODING_MODE, 12'(MODE_PACKED_ALT), '0},
      '{ROW_CFG, REG_ROW_WIDTH, 12'd0, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h000, '0},
      '{ROW_CFG, REG_ROW_WIDTH, 12'd4095, '0},
      '{ROW_CFG, REG_CODING_MODE, 12'(MODE_RAW), '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h080, '0},
      '{ROW_CFG, REG_ROW_WIDTH, 12'd1, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h042, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h043, '0},
      '{ROW_CFG, REG_CODING_MODE, 12'(MODE_PAIR), '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h0FE, '0},
      '{ROW_BYTE, REG_CODING_MODE, 12'h000, '0}
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_byte(plan[i].value[7:0], plan[i].kind == ROW_TYPED, plan[i].exp_run);
      end
    end

    for (pass_no = 0; pass_no < 3; pass_no++) begin
      send_idle = (pass_no == 0) ? 15 : (pass_no == 1) ? 82 : 0;
      recv_idle = (pass_no == 0) ? 82 : (pass_no == 1) ? 15 : 0;
      pass_end = items_sent + 550;
      while (items_sent < pass_end) begin
        wait_idle();
        pick = $urandom_range(0, 9);
        width = (pick == 0) ? 12'd1 : (pick == 1) ? 12'd4095 :
                (pick < 7) ? 12'($urandom_range(1, 16)) : 12'($urandom_range(1, 300));
        // The image must not end before the last phase, so the row count stays high.
        rows = ($urandom_range(0, 3) == 0) ? 12'd4095 : 12'($urandom_range(2500, 4095));
        left = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0)
                                           : 12'($urandom);
        top = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0)
                                          : 12'($urandom);
        write_reg(REG_CODING_MODE, 12'($urandom_range(0, 3)));
        write_reg(REG_ROW_WIDTH, width);
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_LEFT_MARGIN, left);
        write_reg(REG_TOP_MARGIN, top);
        sub_end = items_sent + $urandom_range(40, 140);
        while (items_sent < sub_end) send_segment();
      end
    end

    // Close the image on the current row, then check that later bytes are dropped.
    wait_idle();
    write_reg(REG_ROW_COUNT, 12'd1);
    write_reg(REG_ROW_WIDTH, 12'd4095);
    write_reg(REG_CODING_MODE, 12'(MODE_PACKED));
    while (!img_finished) send_byte({3'($urandom_range(0, 6)), 5'd31});
    repeat (4) send_byte(8'($urandom));

    wait_idle();
    if (runs_due.size() != 0) begin
      $error("%0d expected runs never arrived", runs_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/sprd_pkg.sv
sv/sprd_step.sv
sv/sprite_rle_row_decoder.sv
bench/tb_top.sv
